// ----- src/msn_pkg.sv -----
// Package for the map sheet neighbour step block.
// Zone limits, direction codes, scale codes and the sheet count lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msn_pkg;

  localparam int unsigned LAT_ZONES = 22;
  localparam int unsigned LON_ZONES = 60;

  localparam logic [4:0] LAT_ZONE_LAST = 5'(LAT_ZONES);
  localparam logic [5:0] LON_ZONE_LAST = 6'(LON_ZONES);

  // Compass direction codes
  localparam logic [3:0] DIR_NW = 4'd1;
  localparam logic [3:0] DIR_N  = 4'd2;
  localparam logic [3:0] DIR_NE = 4'd3;
  localparam logic [3:0] DIR_W  = 4'd4;
  localparam logic [3:0] DIR_E  = 4'd5;
  localparam logic [3:0] DIR_SW = 4'd6;
  localparam logic [3:0] DIR_S  = 4'd7;
  localparam logic [3:0] DIR_SE = 4'd8;

  // Scale letters B..H
  localparam logic [2:0] SCALE_B = 3'd0;
  localparam logic [2:0] SCALE_C = 3'd1;
  localparam logic [2:0] SCALE_D = 3'd2;
  localparam logic [2:0] SCALE_E = 3'd3;
  localparam logic [2:0] SCALE_F = 3'd4;
  localparam logic [2:0] SCALE_G = 3'd5;
  localparam logic [2:0] SCALE_H = 3'd6;

  // Sheets per zone side; zero marks an unknown scale letter
  function automatic logic [7:0] sheet_count(input logic [2:0] code);
    logic [7:0] n;
    unique case (code)
      SCALE_B: n = 8'd2;
      SCALE_C: n = 8'd4;
      SCALE_D: n = 8'd12;
      SCALE_E: n = 8'd24;
      SCALE_F: n = 8'd48;
      SCALE_G: n = 8'd96;
      SCALE_H: n = 8'd192;
      default: n = 8'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- src/msn_in_if.sv -----
// Request channel of the map sheet neighbour step block.
// Carries valid, ready and one sheet designation with a direction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface msn_in_if;
  logic       valid;
  logic       ready;
  logic       south;
  logic [4:0] zone_row;
  logic [6:0] zone_col;
  logic [2:0] scale_code;
  logic [9:0] sheet_row;
  logic [9:0] sheet_col;
  logic [3:0] req_type;

  modport source (
    output valid, south, zone_row, zone_col, scale_code, sheet_row, sheet_col, req_type,
    input  ready
  );

  modport sink (
    input  valid, south, zone_row, zone_col, scale_code, sheet_row, sheet_col, req_type,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/msn_out_if.sv -----
// Result channel of the map sheet neighbour step block.
// Carries valid, ready and the neighbouring sheet with its status flags.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface msn_out_if;
  logic       valid;
  logic       ready;
  logic       input_ok;
  logic       out_of_range;
  logic       new_south;
  logic [4:0] new_zone_row;
  logic [5:0] new_zone_col;
  logic [7:0] new_sheet_row;
  logic [7:0] new_sheet_col;

  modport source (
    output valid, input_ok, out_of_range, new_south, new_zone_row, new_zone_col,
           new_sheet_row, new_sheet_col,
    input  ready
  );

  modport sink (
    input  valid, input_ok, out_of_range, new_south, new_zone_row, new_zone_col,
           new_sheet_row, new_sheet_col,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/map_sheet_neighbour_step.sv -----
// Map sheet neighbour step: validates a sheet designation and gives its
// neighbour in one of eight compass directions.
// Depends on msn_pkg, msn_in_if and msn_out_if.
//
//   channel  direction  interface        contents
//   in_i     sink       msn_in_if.sink   designation and direction
//   out_o    source     msn_out_if.source status flags and neighbour sheet
//
// Two register stages: the input register holds the accepted request, the
// result register holds the computed neighbour. An accepted request moves from
// the input register into the result register once that register is free;
// one request is taken every cycle while the output is not stalled.
// rst_ni clears both valid flags only. A stalled output holds the result
// register; the input register takes a request while it is empty or while its
// content moves on into the result register in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module map_sheet_neighbour_step
  import msn_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  msn_in_if.sink     in_i,
  msn_out_if.source  out_o
);

  // Input register
  logic       req_valid_q;
  logic       south_q;
  logic [4:0] zone_row_q;
  logic [6:0] zone_col_q;
  logic [2:0] scale_code_q;
  logic [9:0] sheet_row_q;
  logic [9:0] sheet_col_q;
  logic [3:0] req_type_q;

  // Result register
  logic       res_valid_q;
  logic       input_ok_q, input_ok_d;
  logic       oor_q, oor_d;
  logic       new_south_q, new_south_d;
  logic [4:0] new_zone_row_q, new_zone_row_d;
  logic [5:0] new_zone_col_q, new_zone_col_d;
  logic [7:0] new_sheet_row_q, new_sheet_row_d;
  logic [7:0] new_sheet_col_q, new_sheet_col_d;

  logic res_free;
  logic req_free;

  assign res_free = !res_valid_q || out_o.ready;
  assign req_free = !req_valid_q || res_free;
  assign in_i.ready = req_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_free) begin
      req_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_free && in_i.valid) begin
      south_q      <= in_i.south;
      zone_row_q   <= in_i.zone_row;
      zone_col_q   <= in_i.zone_col;
      scale_code_q <= in_i.scale_code;
      sheet_row_q  <= in_i.sheet_row;
      sheet_col_q  <= in_i.sheet_col;
      req_type_q   <= in_i.req_type;
    end
  end

  // Neighbour computation
  logic [7:0] n;
  logic       valid_desig;
  logic       go_n, go_s, go_w, go_e;
  logic       hemi;
  logic [4:0] zr;
  logic [5:0] zc;
  logic [7:0] r, c;
  logic       oor;

  always_comb begin
    n = sheet_count(scale_code_q);
    valid_desig = (zone_row_q >= 5'd1) && (zone_row_q <= LAT_ZONE_LAST)
               && (zone_col_q >= 7'd1) && (zone_col_q <= {1'b0, LON_ZONE_LAST})
               && (n != 8'd0)
               && (sheet_row_q >= 10'd1) && (sheet_row_q <= {2'b00, n})
               && (sheet_col_q >= 10'd1) && (sheet_col_q <= {2'b00, n});

    go_n = (req_type_q == DIR_NW) || (req_type_q == DIR_N) || (req_type_q == DIR_NE);
    go_s = (req_type_q == DIR_SW) || (req_type_q == DIR_S) || (req_type_q == DIR_SE);
    go_w = (req_type_q == DIR_NW) || (req_type_q == DIR_W) || (req_type_q == DIR_SW);
    go_e = (req_type_q == DIR_NE) || (req_type_q == DIR_E) || (req_type_q == DIR_SE);

    // Field values only matter once the designation is known to be valid
    hemi = south_q;
    zr   = zone_row_q;
    zc   = zone_col_q[5:0];
    r    = sheet_row_q[7:0];
    c    = sheet_col_q[7:0];
    oor  = 1'b0;

    if (go_n) begin
      if (r > 8'd1) begin
        r = r - 8'd1;
      end else begin
        r = n;
        if (hemi) begin
          if (zr <= 5'd1) hemi = 1'b0;
          else            zr = zr - 5'd1;
        end else begin
          if (zr >= LAT_ZONE_LAST) oor = 1'b1;
          else                     zr = zr + 5'd1;
        end
      end
    end else if (go_s) begin
      if (r < n) begin
        r = r + 8'd1;
      end else begin
        r = 8'd1;
        if (!hemi) begin
          if (zr <= 5'd1) hemi = 1'b1;
          else            zr = zr - 5'd1;
        end else begin
          if (zr >= LAT_ZONE_LAST) oor = 1'b1;
          else                     zr = zr + 5'd1;
        end
      end
    end

    if (go_w) begin
      if (c > 8'd1) begin
        c = c - 8'd1;
      end else begin
        c  = n;
        zc = (zc <= 6'd1) ? LON_ZONE_LAST : zc - 6'd1;
      end
    end else if (go_e) begin
      if (c < n) begin
        c = c + 8'd1;
      end else begin
        c  = 8'd1;
        zc = (zc >= LON_ZONE_LAST) ? 6'd1 : zc + 6'd1;
      end
    end

    input_ok_d      = valid_desig;
    oor_d           = valid_desig && oor;
    new_south_d     = 1'b0;
    new_zone_row_d  = '0;
    new_zone_col_d  = '0;
    new_sheet_row_d = '0;
    new_sheet_col_d = '0;
    if (valid_desig && !oor) begin
      new_south_d     = hemi;
      new_zone_row_d  = zr;
      new_zone_col_d  = zc;
      new_sheet_row_d = r;
      new_sheet_col_d = c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && req_valid_q) begin
      input_ok_q      <= input_ok_d;
      oor_q           <= oor_d;
      new_south_q     <= new_south_d;
      new_zone_row_q  <= new_zone_row_d;
      new_zone_col_q  <= new_zone_col_d;
      new_sheet_row_q <= new_sheet_row_d;
      new_sheet_col_q <= new_sheet_col_d;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.input_ok      = input_ok_q;
  assign out_o.out_of_range  = oor_q;
  assign out_o.new_south     = new_south_q;
  assign out_o.new_zone_row  = new_zone_row_q;
  assign out_o.new_zone_col  = new_zone_col_q;
  assign out_o.new_sheet_row = new_sheet_row_q;
  assign out_o.new_sheet_col = new_sheet_col_q;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for map_sheet_neighbour_step: directed corner, no-step and malformed
// sheets, then random designations, with an in-bench neighbour predictor and in-order result checks.
// Depends on msn_pkg, msn_in_if, msn_out_if and the block itself.
`timescale 1ns / 1ps

module tb;
  import msn_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned CALM_TAIL    = 60;
  localparam int unsigned PRESSURE_AT  = 150;
  localparam int unsigned PRESSURE_LEN = 60;
  localparam int unsigned DRAIN_CYCLES = 10;

  // Direction codes that name no compass step
  localparam logic [3:0] DIR_NONE_LO  = 4'd0;
  localparam logic [3:0] DIR_NONE_MID = 4'd9;
  localparam logic [3:0] DIR_NONE_HI  = 4'd15;
  localparam logic [2:0] SCALE_BAD    = 3'd7;

  typedef struct packed {
    logic       south;
    logic [4:0] zone_row;
    logic [6:0] zone_col;
    logic [2:0] scale_code;
    logic [9:0] sheet_row;
    logic [9:0] sheet_col;
    logic [3:0] req_type;
  } sheet_req_t;

  typedef struct packed {
    logic       input_ok;
    logic       out_of_range;
    logic       new_south;
    logic [4:0] new_zone_row;
    logic [5:0] new_zone_col;
    logic [7:0] new_sheet_row;
    logic [7:0] new_sheet_col;
  } sheet_res_t;

  logic clk_i;
  logic rst_ni;

  msn_in_if  in_if ();
  msn_out_if out_if ();

  map_sheet_neighbour_step u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sheet_req_t  request_q[$];
  sheet_res_t  neighbour_q[$];
  int unsigned request_total;
  int unsigned taken_cnt;
  int unsigned fault_cnt;
  int unsigned cycle_cnt;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          pressure_done;
  bit          in_xfer;

  always #1 clk_i = ~clk_i;

  function automatic int unsigned sheets_per_side(logic [2:0] scale);
    case (scale)
      SCALE_B: return 2;
      SCALE_C: return 4;
      SCALE_D: return 12;
      SCALE_E: return 24;
      SCALE_F: return 48;
      SCALE_G: return 96;
      SCALE_H: return 192;
      default: return 0;
    endcase
  endfunction

  function automatic sheet_res_t neighbour_sheet(sheet_req_t q);
    sheet_res_t  r;
    int unsigned side;
    int unsigned zrow;
    int unsigned zcol;
    int unsigned row;
    int unsigned col;
    logic        hemi;
    logic        beyond;
    r      = '0;
    side   = sheets_per_side(q.scale_code);
    zrow   = q.zone_row;
    zcol   = q.zone_col;
    row    = q.sheet_row;
    col    = q.sheet_col;
    hemi   = q.south;
    beyond = 1'b0;
    if (zrow < 1 || zrow > LAT_ZONES || zcol < 1 || zcol > LON_ZONES || side == 0 ||
        row < 1 || row > side || col < 1 || col > side) begin
      return r;
    end
    // Vertical part first; rows count from the north edge in both hemispheres
    if (q.req_type inside {DIR_NW, DIR_N, DIR_NE}) begin
      if (row > 1) begin
        row--;
      end else begin
        row = side;
        if (hemi) begin
          if (zrow <= 1) hemi = 1'b0;
          else zrow--;
        end else if (zrow >= LAT_ZONES) begin
          beyond = 1'b1;
        end else begin
          zrow++;
        end
      end
    end else if (q.req_type inside {DIR_SW, DIR_S, DIR_SE}) begin
      if (row < side) begin
        row++;
      end else begin
        row = 1;
        if (!hemi) begin
          if (zrow <= 1) hemi = 1'b1;
          else zrow--;
        end else if (zrow >= LAT_ZONES) begin
          beyond = 1'b1;
        end else begin
          zrow++;
        end
      end
    end
    if (q.req_type inside {DIR_NW, DIR_W, DIR_SW}) begin
      if (col > 1) begin
        col--;
      end else begin
        col  = side;
        zcol = (zcol <= 1) ? LON_ZONES : zcol - 1;
      end
    end else if (q.req_type inside {DIR_NE, DIR_E, DIR_SE}) begin
      if (col < side) begin
        col++;
      end else begin
        col  = 1;
        zcol = (zcol >= LON_ZONES) ? 1 : zcol + 1;
      end
    end
    r.input_ok = 1'b1;
    if (beyond) begin
      r.out_of_range = 1'b1;
      return r;
    end
    r.new_south     = hemi;
    r.new_zone_row  = 5'(zrow);
    r.new_zone_col  = 6'(zcol);
    r.new_sheet_row = 8'(row);
    r.new_sheet_col = 8'(col);
    return r;
  endfunction

  function automatic sheet_req_t sheet_at(int unsigned s, int unsigned zr, int unsigned zc,
                                          logic [2:0] scale, int unsigned row,
                                          int unsigned col, logic [3:0] dir);
    sheet_req_t q;
    q.south      = 1'(s);
    q.zone_row   = 5'(zr);
    q.zone_col   = 7'(zc);
    q.scale_code = scale;
    q.sheet_row  = 10'(row);
    q.sheet_col  = 10'(col);
    q.req_type   = dir;
    return q;
  endfunction

  // Mostly well-formed sheets biased to zone and sheet edges; the rest raw noise
  function automatic sheet_req_t random_sheet();
    sheet_req_t  q;
    int unsigned side;
    if ($urandom_range(0, 4) == 0) begin
      q = sheet_req_t'(40'({$urandom, $urandom}));
      return q;
    end
    q.scale_code = 3'($urandom_range(0, 6));
    side         = sheets_per_side(q.scale_code);
    q.south      = 1'($urandom_range(0, 1));
    q.zone_row   = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 5'd1 : 5'(LAT_ZONES))
                                               : 5'($urandom_range(1, LAT_ZONES));
    q.zone_col   = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 7'd1 : 7'(LON_ZONES))
                                               : 7'($urandom_range(1, LON_ZONES));
    q.sheet_row  = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 10'd1 : 10'(side))
                                               : 10'($urandom_range(1, side));
    q.sheet_col  = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 10'd1 : 10'(side))
                                               : 10'($urandom_range(1, side));
    q.req_type   = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 8));
    return q;
  endfunction

  task automatic check_field(string name, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fault_cnt++;
    end
  endtask

  // Sender: hold an untaken request, otherwise idle in bursts or offer the next one
  always @(negedge clk_i) begin : drive_requests
    if (!rst_ni || request_q.size() == 0) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_xfer) begin
      in_if.valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_if.valid <= 1'b0;
    end else if (taken_cnt + CALM_TAIL < request_total && $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(0, 6);
      in_if.valid <= 1'b0;
    end else begin
      in_if.valid      <= 1'b1;
      in_if.south      <= request_q[0].south;
      in_if.zone_row   <= request_q[0].zone_row;
      in_if.zone_col   <= request_q[0].zone_col;
      in_if.scale_code <= request_q[0].scale_code;
      in_if.sheet_row  <= request_q[0].sheet_row;
      in_if.sheet_col  <= request_q[0].sheet_col;
      in_if.req_type   <= request_q[0].req_type;
    end
  end

  // Receiver: one long hold-off to back the block up, random stalls otherwise
  always @(negedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!pressure_done && taken_cnt >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      hold_left     = PRESSURE_LEN - 1;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (taken_cnt + CALM_TAIL < request_total && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watch
    sheet_req_t seen;
    sheet_res_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("map_sheet_neighbour_step regression: fail");
      $finish;
    end else if (rst_ni) begin
      in_xfer = in_if.valid && in_if.ready;
      if (in_xfer) begin
        seen = sheet_at(in_if.south, in_if.zone_row, in_if.zone_col, in_if.scale_code,
                        in_if.sheet_row, in_if.sheet_col, in_if.req_type);
        neighbour_q.push_back(neighbour_sheet(seen));
        void'(request_q.pop_front());
        taken_cnt++;
      end
      if (out_if.valid && out_if.ready) begin
        if (neighbour_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          fault_cnt++;
        end else begin
          want = neighbour_q.pop_front();
          check_field("input_ok", 10'(want.input_ok), 10'(out_if.input_ok));
          check_field("out_of_range", 10'(want.out_of_range), 10'(out_if.out_of_range));
          check_field("new_south", 10'(want.new_south), 10'(out_if.new_south));
          check_field("new_zone_row", 10'(want.new_zone_row), 10'(out_if.new_zone_row));
          check_field("new_zone_col", 10'(want.new_zone_col), 10'(out_if.new_zone_col));
          check_field("new_sheet_row", 10'(want.new_sheet_row),
                      10'(out_if.new_sheet_row));
          check_field("new_sheet_col", 10'(want.new_sheet_col),
                      10'(out_if.new_sheet_col));
        end
      end
    end
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.south      = 1'b0;
    in_if.zone_row   = '0;
    in_if.zone_col   = '0;
    in_if.scale_code = '0;
    in_if.sheet_row  = '0;
    in_if.sheet_col  = '0;
    in_if.req_type   = '0;
    out_if.ready     = 1'b0;
    taken_cnt        = 0;
    fault_cnt        = 0;
    cycle_cnt        = 0;
    send_gap         = 0;
    stall_left       = 0;
    hold_left        = 0;
    pressure_done    = 1'b0;
    in_xfer          = 1'b0;

    // Beyond the last zone, both hemispheres
    request_q.push_back(sheet_at(0, 22, 30, SCALE_H, 1, 100, DIR_N));
    request_q.push_back(sheet_at(1, 22, 30, SCALE_G, 96, 5, DIR_S));
    // Equator crossings
    request_q.push_back(sheet_at(1, 1, 10, SCALE_D, 1, 6, DIR_N));
    request_q.push_back(sheet_at(0, 1, 10, SCALE_D, 12, 6, DIR_S));
    request_q.push_back(sheet_at(1, 1, 60, SCALE_H, 1, 192, DIR_NE));
    request_q.push_back(sheet_at(0, 1, 1, SCALE_B, 2, 1, DIR_SW));
    // Zone steps away from the equator and longitude wrap
    request_q.push_back(sheet_at(0, 5, 10, SCALE_C, 1, 2, DIR_NW));
    request_q.push_back(sheet_at(1, 5, 10, SCALE_B, 2, 2, DIR_SE));
    request_q.push_back(sheet_at(0, 7, 1, SCALE_E, 3, 1, DIR_W));
    request_q.push_back(sheet_at(1, 7, 60, SCALE_F, 3, 48, DIR_E));
    request_q.push_back(sheet_at(0, 3, 1, SCALE_H, 1, 1, DIR_NW));
    request_q.push_back(sheet_at(0, 22, 60, SCALE_H, 192, 192, DIR_SE));
    // No compass step
    request_q.push_back(sheet_at(0, 12, 30, SCALE_E, 5, 5, DIR_NONE_LO));
    request_q.push_back(sheet_at(1, 12, 30, SCALE_E, 24, 1, DIR_NONE_MID));
    request_q.push_back(sheet_at(1, 22, 60, SCALE_H, 192, 192, DIR_NONE_HI));
    // Malformed designations
    request_q.push_back(sheet_at(0, 0, 30, SCALE_E, 5, 5, DIR_N));
    request_q.push_back(sheet_at(0, 23, 30, SCALE_E, 5, 5, DIR_S));
    request_q.push_back(sheet_at(1, 31, 30, SCALE_E, 5, 5, DIR_E));
    request_q.push_back(sheet_at(0, 4, 0, SCALE_E, 5, 5, DIR_W));
    request_q.push_back(sheet_at(0, 4, 61, SCALE_E, 5, 5, DIR_W));
    request_q.push_back(sheet_at(1, 4, 127, SCALE_E, 5, 5, DIR_NE));
    request_q.push_back(sheet_at(0, 4, 30, SCALE_BAD, 1, 1, DIR_SE));
    request_q.push_back(sheet_at(0, 4, 30, SCALE_D, 0, 1, DIR_N));
    request_q.push_back(sheet_at(0, 4, 30, SCALE_D, 13, 1, DIR_N));
    request_q.push_back(sheet_at(1, 4, 30, SCALE_H, 1023, 1, DIR_S));
    request_q.push_back(sheet_at(1, 4, 30, SCALE_H, 1, 1023, DIR_SW));
    repeat (RANDOM_ITEMS) request_q.push_back(random_sheet());
    request_total = request_q.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || neighbour_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("map_sheet_neighbour_step regression: pass");
    end else begin
      $display("map_sheet_neighbour_step regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/msn_pkg.sv
src/msn_in_if.sv
src/msn_out_if.sv
src/map_sheet_neighbour_step.sv
tb/tb.sv
